[src/plist_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the positional list engine: request codes, port widths,
// parameter defaults and the control word broadcast to the row of storage cells.
// No dependencies.
package plist_pkg;

    // Port widths fixed by the item format.
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // Defaults for the top-level parameters.
    localparam int LIST_DEPTH_DEF  = 64;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Request codes.
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    // Control word that every cell sees in the same cycle.
    typedef struct packed {
        logic write_pos;   // the cell at the index takes the new entry
        logic shift_up;    // cells above the index take their lower neighbor
        logic shift_down;  // cells at and above the index take their upper neighbor
        logic rd_load;     // every cell copies its entry into its read register
        logic rd_shift;    // read registers move one cell toward cell zero
    } cell_ctl_t;

    // One result item.
    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  read_data;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

[src/plist_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the positional list: holds a single entry and a read register.
// Depends on plist_pkg for the cell control word.
module plist_cell #(
    parameter int ENTRY_WIDTH = plist_pkg::ENTRY_WIDTH_DEF,
    parameter int IDX_W       = 6,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  plist_pkg::cell_ctl_t   ctl,
    input  logic [IDX_W-1:0]       idx,
    input  logic [ENTRY_WIDTH-1:0] wr_data,
    input  logic [ENTRY_WIDTH-1:0] left_entry,
    input  logic [ENTRY_WIDTH-1:0] right_entry,
    input  logic [ENTRY_WIDTH-1:0] right_rd,
    output logic [ENTRY_WIDTH-1:0] entry,
    output logic [ENTRY_WIDTH-1:0] rd
);
    import plist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [ENTRY_WIDTH-1:0] entry_next;
    logic [ENTRY_WIDTH-1:0] rd_reg;
    logic [ENTRY_WIDTH-1:0] rd_next;
    logic                   hit;
    logic                   above;

    assign hit   = (idx == MY_IDX);
    assign above = (MY_IDX > idx);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.write_pos && hit)
        begin
            entry_next = wr_data;
        end
        else if (ctl.shift_up)
        begin
            if (hit)
            begin
                entry_next = wr_data;
            end
            else if (above)
            begin
                entry_next = left_entry;
            end
        end
        else if (ctl.shift_down && (hit || above))
        begin
            entry_next = right_entry;
        end
    end

    // A read snapshots the whole row, then walks it toward cell zero.
    always_comb
    begin
        rd_next = rd_reg;
        if (ctl.rd_load)
        begin
            rd_next = entry_reg;
        end
        else if (ctl.rd_shift)
        begin
            rd_next = right_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

[src/positional_list_engine.sv]
`timescale 1ns / 1ps
// Top level of the positional list engine: request decode, live count, read
// sequencer, two-deep result buffer and the row of storage cells (plist_cell).
// Depends on plist_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------
//   in      | in_valid, in_stall | op, position, entry_data
//   out     | out_valid, out_stall | ok, read_data, entry_count
//
// Append, replace, remove, insert, clear and any failed request finish at the
// edge that accepts them; their result item is offered in the next cycle, and
// one such request can be accepted every cycle while the result buffer has room.
// A successful read snapshots the row at acceptance; the selected entry then
// walks one cell per cycle down the read chain to cell zero, and its result
// is posted when it arrives there; no request is accepted during that walk.
// Reset clears the live count, the read sequencer and the result buffer; the
// entries themselves are undefined until written.
// in_stall rises only when the result buffer holds two items or a read walk is
// running, so an item is still taken while one finished result waits.
module positional_list_engine #(
    parameter int LIST_DEPTH  = plist_pkg::LIST_DEPTH_DEF,
    parameter int ENTRY_WIDTH = plist_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [plist_pkg::OP_W-1:0]    op,
    input  logic [plist_pkg::POS_W-1:0]   position,
    input  logic [plist_pkg::DATA_W-1:0]  entry_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [plist_pkg::DATA_W-1:0]  read_data,
    output logic [plist_pkg::COUNT_W-1:0] entry_count
);
    import plist_pkg::*;

    // Count holds 0..LIST_DEPTH, a cell index 0..LIST_DEPTH-1. Range checks use
    // a width that holds both the count and the position port.
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic       ST_IDLE = 1'b0;
    localparam logic       ST_READ = 1'b1;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    // Control state.
    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] rd_cnt_reg;
    logic [IDX_W-1:0] rd_cnt_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;

    // Result buffer payload.
    result_t head_reg;
    result_t head_next;
    result_t spare_reg;
    result_t spare_next;

    // Decode of the request at the input.
    cell_ctl_t        dec_ctl;
    logic [IDX_W-1:0] dec_idx;
    logic             dec_ok;
    logic             dec_read;
    logic [CNT_W-1:0] dec_count;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             full;

    logic             in_fire;
    logic             pop;
    logic             push;
    result_t          push_res;
    cell_ctl_t        cell_ctl;

    logic [ENTRY_WIDTH-1:0] wr_entry;
    logic [ENTRY_WIDTH-1:0] entry_w [LIST_DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_w    [LIST_DEPTH];

    assign in_stall = (state_reg != ST_IDLE) || (fill_reg == FILL_TWO);
    assign in_fire  = in_valid && !in_stall;

    assign pos_x    = CMP_W'(position);
    assign cnt_x    = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(LIST_DEPTH));
    assign wr_entry = ENTRY_WIDTH'(entry_data);

    // Every request is judged against the live count; a failed one leaves the
    // row and the count as they are.
    always_comb
    begin
        dec_ctl   = '0;
        dec_idx   = IDX_W'(position);
        dec_ok    = 1'b0;
        dec_read  = 1'b0;
        dec_count = count_reg;
        case (op)
            OP_APPEND:
            begin
                dec_idx = IDX_W'(count_reg);
                if (!full)
                begin
                    dec_ctl.write_pos = 1'b1;
                    dec_ok            = 1'b1;
                    dec_count         = count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    dec_ctl.rd_load = 1'b1;
                    dec_ok          = 1'b1;
                    dec_read        = 1'b1;
                end
            end
            OP_REPLACE:
            begin
                if (pos_x < cnt_x)
                begin
                    dec_ctl.write_pos = 1'b1;
                    dec_ok            = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_x < cnt_x)
                begin
                    dec_ctl.shift_down = 1'b1;
                    dec_ok             = 1'b1;
                    dec_count          = count_reg - CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if ((pos_x <= cnt_x) && !full)
                begin
                    dec_ctl.shift_up = 1'b1;
                    dec_ok           = 1'b1;
                    dec_count        = count_reg + CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                dec_ok    = 1'b1;
                dec_count = '0;
            end
            default:
            begin
                dec_ok = 1'b0;
            end
        endcase
    end

    // Sequencer: every request but a good read posts its result at once; a good read
    // walks the snapshot down the chain until the wanted entry reaches cell zero.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        cell_ctl    = '0;
        push        = 1'b0;
        push_res    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cell_ctl   = dec_ctl;
                    count_next = dec_count;
                    if (dec_read)
                    begin
                        state_next  = ST_READ;
                        rd_cnt_next = IDX_W'(position);
                    end
                    else
                    begin
                        push                 = 1'b1;
                        push_res.ok          = dec_ok;
                        push_res.entry_count = COUNT_W'(dec_count);
                    end
                end
            end
            ST_READ:
            begin
                if (rd_cnt_reg == '0)
                begin
                    push                 = 1'b1;
                    push_res.ok          = 1'b1;
                    push_res.read_data   = DATA_W'(rd_w[0]);
                    push_res.entry_count = COUNT_W'(count_reg);
                    state_next           = ST_IDLE;
                end
                else
                begin
                    cell_ctl.rd_shift = 1'b1;
                    rd_cnt_next       = rd_cnt_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Two-deep result buffer. A push never meets a full buffer: requests are only
    // taken below two, and a read walk blocks further requests.
    assign out_valid = (fill_reg != FILL_NONE);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        fill_next  = fill_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        case (fill_reg)
            FILL_NONE:
            begin
                if (push)
                begin
                    head_next = push_res;
                    fill_next = FILL_ONE;
                end
            end
            FILL_ONE:
            begin
                if (push && pop)
                begin
                    head_next = push_res;
                end
                else if (push)
                begin
                    spare_next = push_res;
                    fill_next  = FILL_TWO;
                end
                else if (pop)
                begin
                    fill_next = FILL_NONE;
                end
            end
            FILL_TWO:
            begin
                if (pop)
                begin
                    head_next = spare_reg;
                    fill_next = FILL_ONE;
                end
            end
            default:
            begin
                fill_next = FILL_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            fill_reg   <= FILL_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign ok          = head_reg.ok;
    assign read_data   = head_reg.read_data;
    assign entry_count = head_reg.entry_count;

    // The row of cells. Each cell sees its two neighbors' entries and the read
    // register of the cell above it; the ends of the row see zero.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [ENTRY_WIDTH-1:0] left_entry;
        logic [ENTRY_WIDTH-1:0] right_entry;
        logic [ENTRY_WIDTH-1:0] right_rd;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_inner_lo
            assign left_entry = entry_w[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
            assign right_rd    = '0;
        end
        else
        begin : g_inner_hi
            assign right_entry = entry_w[i+1];
            assign right_rd    = rd_w[i+1];
        end

        plist_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .IDX_W       (IDX_W),
            .INDEX       (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .idx         (dec_idx),
            .wr_data     (wr_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .right_rd    (right_rd),
            .entry       (entry_w[i]),
            .rd          (rd_w[i])
        );
    end

endmodule
